// ===== rtl/sfp_pkg.sv =====
// Package for the SPS frame size parser: syntax step codes, status codes,
// the parse state record and the result record. No dependencies.
`timescale 1ns / 1ps

package sfp_pkg;

    localparam int DEFAULT_MAX_MBS = 4096;
    localparam int MBS_W           = 13;
    localparam int SIZE_W          = 17;
    localparam int STATUS_W        = 3;
    localparam int OUT_DATA_W      = 40;

    typedef logic [4:0] t_step;

    localparam t_step ST_HDR        = 5'd0;
    localparam t_step ST_PROFILE    = 5'd1;
    localparam t_step ST_FLAGS      = 5'd2;
    localparam t_step ST_LEVEL      = 5'd3;
    localparam t_step ST_SPS_ID     = 5'd4;
    localparam t_step ST_CHROMA     = 5'd5;
    localparam t_step ST_RESID      = 5'd6;
    localparam t_step ST_DEPTH_L    = 5'd7;
    localparam t_step ST_DEPTH_C    = 5'd8;
    localparam t_step ST_BYPASS     = 5'd9;
    localparam t_step ST_SCAL_PRES  = 5'd10;
    localparam t_step ST_SCAL_FLAGS = 5'd11;
    localparam t_step ST_FRAME_NUM  = 5'd12;
    localparam t_step ST_POC_TYPE   = 5'd13;
    localparam t_step ST_POC_LSB    = 5'd14;
    localparam t_step ST_DELTA_ZERO = 5'd15;
    localparam t_step ST_OFF_NONREF = 5'd16;
    localparam t_step ST_OFF_TB     = 5'd17;
    localparam t_step ST_CYCLE_LEN  = 5'd18;
    localparam t_step ST_CYCLE_OFF  = 5'd19;
    localparam t_step ST_NUM_REF    = 5'd20;
    localparam t_step ST_GAPS       = 5'd21;
    localparam t_step ST_WIDTH      = 5'd22;
    localparam t_step ST_HEIGHT     = 5'd23;
    localparam t_step ST_DONE       = 5'd24;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status STATUS_OK      = 3'd0;
    localparam t_status STATUS_NOT_SPS = 3'd1;
    localparam t_status STATUS_EARLY   = 3'd2;
    localparam t_status STATUS_LONG    = 3'd3;
    localparam t_status STATUS_TOO_BIG = 3'd4;

    localparam logic [7:0] PROFILE_HIGH     = 8'd100;
    localparam logic [7:0] PROFILE_HIGH10   = 8'd110;
    localparam logic [7:0] PROFILE_HIGH422  = 8'd122;
    localparam logic [7:0] PROFILE_HIGH444  = 8'd144;
    localparam logic [4:0] NAL_TYPE_SPS     = 5'd7;
    localparam logic [31:0] CHROMA_444      = 32'd3;

    typedef struct packed {
        t_step             step;
        logic [3:0]        bits_left;
        logic              phase;
        logic [5:0]        lz_count;
        logic [31:0]       acc;
        logic [7:0]        profile;
        logic [1:0]        poc_kind;
        logic [31:0]       repeat_left;
        logic [MBS_W-1:0]  width_mbs;
        logic [MBS_W-1:0]  height_units;
        logic [2:0]        outcome;
    } t_parse_state;

    typedef struct packed {
        logic [SIZE_W-1:0] frame_height;
        logic [SIZE_W-1:0] frame_width;
        t_status           status;
    } t_result;

    // Width of a fixed-length field, zero for an Exp-Golomb step.
    function automatic logic [3:0] fixed_width(input t_step step);
        logic [3:0] w;
        case (step)
            ST_HDR, ST_PROFILE, ST_FLAGS, ST_LEVEL, ST_SCAL_FLAGS: w = 4'd8;
            ST_RESID, ST_BYPASS, ST_SCAL_PRES, ST_DELTA_ZERO, ST_GAPS: w = 4'd1;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/h264_sps_frame_size_parser_core.sv =====
// H.264 SPS frame size parser: top level with input and output registers.
// Depends on sfp_pkg and sfp_parse_engine.
//
// Usage:
//   Slave stream carries the bytes of one NAL unit (tdata = byte, sent MSB
//   first, emulation-prevention bytes left in), tlast on its final byte.
//   Master stream carries one result beat per NAL unit, issued for the tlast
//   beat: status, frame width and frame height in pixels.
// Throughput: one byte per cycle, unless a tlast byte waits on a stalled
//   result beat; all eight bit steps of a byte are worked combinationally
//   from the input register to the parse state register. A taken tlast
//   beat goes through the input register, then the result register.
// Reset: synchronous, active low; clears both valid flags and the parse state,
//   so the next byte is read as a NAL header.
// Stall: while a result beat waits on the master side, non-last bytes keep
//   flowing; a tlast byte holds in the input register until the output
//   register frees, and the slave side stops taking bytes behind it.
`timescale 1ns / 1ps

module h264_sps_frame_size_parser_core #(
    parameter int MAX_MBS = sfp_pkg::DEFAULT_MAX_MBS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // data_byte
    input  logic                           i_s_axis_tlast,  // last_byte
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // status [2:0], frame_width [19:3], frame_height [36:20], zero [39:37]
    output logic [sfp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import sfp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_result;
    logic       w_out_free;
    logic       w_fire;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_fire          = r_in_valid && (!r_in_last || w_out_free);
    assign o_s_axis_tready = !r_in_valid || w_fire;

    sfp_parse_engine #(.MAX_MBS(MAX_MBS)) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step_en (w_fire),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out};

endmodule

// ===== rtl/sfp_bit_step.sv =====
// One bit of the SPS syntax walk: fixed fields and Exp-Golomb codes.
// Combinational; depends on sfp_pkg.
`timescale 1ns / 1ps

module sfp_bit_step #(
    parameter int MAX_MBS = sfp_pkg::DEFAULT_MAX_MBS
) (
    input  sfp_pkg::t_parse_state i_state,
    input  logic                  i_bit,
    output sfp_pkg::t_parse_state o_state
);
    import sfp_pkg::*;

    function automatic t_parse_state finish(input t_parse_state s, input t_status st);
        t_parse_state r;
        r         = s;
        r.outcome = st + 3'd1;
        r.step    = ST_DONE;
        return r;
    endfunction

    function automatic t_parse_state element_done(input t_parse_state s,
                                                  input logic [31:0] v);
        t_parse_state r;
        t_step        nxt;
        logic [31:0]  rep;
        r           = s;
        r.bits_left = 4'd0;
        r.phase     = 1'b0;
        r.lz_count  = 6'd0;
        r.acc       = 32'd0;
        nxt         = s.step + 5'd1;
        rep         = s.repeat_left - 32'd1;
        case (s.step)
            ST_HDR: begin
                if (v[4:0] != NAL_TYPE_SPS) begin
                    r = finish(r, STATUS_NOT_SPS);
                end
            end
            ST_PROFILE: r.profile = v[7:0];
            ST_SPS_ID: begin
                if (!(s.profile == PROFILE_HIGH || s.profile == PROFILE_HIGH10 ||
                      s.profile == PROFILE_HIGH422 || s.profile == PROFILE_HIGH444))
                    nxt = ST_FRAME_NUM;
            end
            ST_CHROMA:    nxt = (v == CHROMA_444) ? ST_RESID : ST_DEPTH_L;
            ST_SCAL_PRES: nxt = (v != 32'd0) ? ST_SCAL_FLAGS : ST_FRAME_NUM;
            ST_POC_TYPE: begin
                if (v == 32'd0) begin
                    r.poc_kind = 2'd0;
                    nxt        = ST_POC_LSB;
                end else if (v == 32'd1) begin
                    r.poc_kind = 2'd1;
                    nxt        = ST_DELTA_ZERO;
                end else begin
                    r.poc_kind = 2'd2;
                    nxt        = ST_NUM_REF;
                end
            end
            ST_POC_LSB: nxt = ST_NUM_REF;
            ST_CYCLE_LEN: begin
                r.repeat_left = v;
                nxt           = (v == 32'd0) ? ST_NUM_REF : ST_CYCLE_OFF;
            end
            ST_CYCLE_OFF: begin
                r.repeat_left = rep;
                nxt           = (rep == 32'd0) ? ST_NUM_REF : ST_CYCLE_OFF;
            end
            ST_WIDTH: begin
                if (v >= 32'(MAX_MBS)) r = finish(r, STATUS_TOO_BIG);
                else r.width_mbs = v[MBS_W-1:0];
            end
            ST_HEIGHT: begin
                if (v >= 32'(MAX_MBS)) begin
                    r = finish(r, STATUS_TOO_BIG);
                end else begin
                    r.height_units = v[MBS_W-1:0];
                    r = finish(r, STATUS_OK);
                end
            end
            default: ;
        endcase
        // finish already parked the step at done
        if (r.outcome == 3'd0) r.step = nxt;
        return r;
    endfunction

    logic [3:0]  w_width;
    logic [3:0]  w_left;
    logic [3:0]  w_left_dec;
    logic [31:0] w_acc;
    logic [31:0] w_acc_sh;
    logic [5:0]  w_lz_dec;

    always_comb begin
        o_state    = i_state;
        w_width    = fixed_width(i_state.step);
        w_left     = (i_state.bits_left == 4'd0) ? w_width : i_state.bits_left;
        w_left_dec = w_left - 4'd1;
        w_acc      = (i_state.bits_left == 4'd0) ? 32'd0 : i_state.acc;
        w_acc_sh   = {i_state.acc[30:0], i_bit};
        w_lz_dec   = i_state.lz_count - 6'd1;
        if (i_state.outcome == 3'd0 && i_state.step < ST_DONE) begin
            if (w_width != 4'd0) begin
                if (w_left_dec == 4'd0) begin
                    o_state = element_done(i_state, {w_acc[30:0], i_bit});
                end else begin
                    o_state.acc       = {w_acc[30:0], i_bit};
                    o_state.bits_left = w_left_dec;
                end
            end else if (!i_state.phase) begin
                if (!i_bit) begin
                    // a 32nd leading zero cannot fit the accumulator
                    if (i_state.lz_count >= 6'd31) o_state = finish(i_state, STATUS_LONG);
                    else o_state.lz_count = i_state.lz_count + 6'd1;
                end else if (i_state.lz_count == 6'd0) begin
                    o_state = element_done(i_state, 32'd0);
                end else begin
                    o_state.acc   = 32'd1;
                    o_state.phase = 1'b1;
                end
            end else begin
                if (w_lz_dec == 6'd0) begin
                    o_state = element_done(i_state, w_acc_sh - 32'd1);
                end else begin
                    o_state.acc      = w_acc_sh;
                    o_state.lz_count = w_lz_dec;
                end
            end
        end
    end

endmodule

// ===== rtl/sfp_parse_engine.sv =====
// Parse state register with eight chained bit steps, one byte per enabled cycle,
// and the result formatting for the last byte. Depends on sfp_pkg, sfp_bit_step.
`timescale 1ns / 1ps

module sfp_parse_engine #(
    parameter int MAX_MBS = sfp_pkg::DEFAULT_MAX_MBS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step_en,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output sfp_pkg::t_result o_result
);
    import sfp_pkg::*;

    t_parse_state r_state;
    t_parse_state n_state;
    t_parse_state w_chain [0:8];
    logic [MBS_W:0] w_w_plus;
    logic [MBS_W:0] w_h_plus;

    assign w_chain[0] = r_state;

    for (genvar gi = 0; gi < 8; gi++) begin : g_bit
        sfp_bit_step #(.MAX_MBS(MAX_MBS)) u_step (
            .i_state (w_chain[gi]),
            .i_bit   (i_byte[7-gi]),
            .o_state (w_chain[gi+1])
        );
    end

    assign w_w_plus = {1'b0, w_chain[8].width_mbs} + 14'd1;
    assign w_h_plus = {1'b0, w_chain[8].height_units} + 14'd1;

    always_comb begin
        if (w_chain[8].outcome == 3'd0) begin
            o_result.status = STATUS_EARLY;
        end else begin
            o_result.status = w_chain[8].outcome - 3'd1;
        end
        if (o_result.status == STATUS_OK) begin
            // (n+1)*16 kept to 17 bits
            o_result.frame_width  = {w_w_plus[MBS_W-1:0], 4'b0000};
            o_result.frame_height = {w_h_plus[MBS_W-1:0], 4'b0000};
        end else begin
            o_result.frame_width  = '0;
            o_result.frame_height = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        if (i_step_en) begin
            // return to the header step after the last beat of a unit
            n_state = i_last ? t_parse_state'('0) : w_chain[8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/sfp_checker.sv =====
// Port-level checks for the SPS frame size parser, bound to the top level.
// Depends on sfp_pkg.
`timescale 1ns / 1ps

module sfp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [sfp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import sfp_pkg::*;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result beat changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
        (o_m_axis_tdata[2:0] == STATUS_OK || o_m_axis_tdata[2:0] == STATUS_NOT_SPS ||
         o_m_axis_tdata[2:0] == STATUS_EARLY || o_m_axis_tdata[2:0] == STATUS_LONG ||
         o_m_axis_tdata[2:0] == STATUS_TOO_BIG))
        else $error("status out of range");

    a_size_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[2:0] != STATUS_OK |->
        o_m_axis_tdata[39:3] == 37'd0)
        else $error("size reported with a failing status");

    // the slave side only stops behind a stalled result beat
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("slave side stalled without a waiting result beat");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat right after reset");

endmodule

bind h264_sps_frame_size_parser_core sfp_checker u_sfp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== dv/tb_h264_sps_frame_size_parser_core.sv =====
// Self-checking testbench for h264_sps_frame_size_parser_core. Builds SPS NAL units
// bit by bit, predicts the status/size report for each unit in step with the byte
// stream, and checks every result beat. Depends on sfp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_h264_sps_frame_size_parser_core;
    import sfp_pkg::*;

    localparam int MAX_MBS    = DEFAULT_MAX_MBS;
    localparam int TIMEOUT_NS = 2_000_000;

    localparam logic [7:0] PROFILE_BASELINE = 8'd66;
    localparam logic [7:0] PROFILE_MAIN     = 8'd77;
    localparam logic [7:0] PROFILE_EXTENDED = 8'd88;

    localparam logic [4:0] NAL_TYPE_UNSPEC = 5'd0;
    localparam logic [4:0] NAL_TYPE_IDR    = 5'd5;
    localparam logic [4:0] NAL_TYPE_TOP    = 5'd31;

    localparam longint unsigned ORDER_KIND_LSB      = 0;
    localparam longint unsigned ORDER_KIND_DELTA    = 1;
    localparam longint unsigned ORDER_KIND_NONE     = 2;
    localparam longint unsigned ORDER_KIND_RESERVED = 9;

    localparam int RX_FREE   = 0;
    localparam int RX_CHOPPY = 1;
    localparam int RX_CHOKED = 2;

    localparam int OFFSET_CAP = 64;

    typedef struct {
        logic [2:0]      hdr_top;      // forbidden bit and reference priority bits
        logic [7:0]      profile;
        longint unsigned chroma;
        logic            resid;
        logic            scal_pres;
        longint unsigned order_kind;
        longint unsigned cycle_len;
        logic            big_offsets;
        longint unsigned width;
        longint unsigned height;
        logic            long_width;
        int              trail;        // whole random bytes after the payload
        int              drop_bits;    // 0 keep all, -1 random cut, else bits cut off
    } sps_plan_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [7:0]            s_tdata = 8'd0;
    logic                  s_tlast = 1'b0;
    logic                  m_tready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    h264_sps_frame_size_parser_core #(
        .MAX_MBS(MAX_MBS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // SPS walk predictor state
    t_step       sps_step;
    logic [3:0]  sps_bits_left;
    logic        sps_in_suffix;
    logic [5:0]  sps_zeros;
    logic [31:0] sps_acc;
    logic [7:0]  sps_profile;
    logic [1:0]  sps_poc_kind;
    logic [31:0] sps_cycle_left;
    logic [12:0] sps_width_m1;
    logic [12:0] sps_height_m1;
    logic [2:0]  sps_outcome;

    t_result pending_reports[$];
    bit      nal_bits[$];
    int      faults = 0;
    int      bytes_sent = 0;
    int      nal_count = 0;
    int      status_hits[0:4] = '{default: 0};
    int      burst_left = 0;
    int      tx_gap_max = 0;
    int      rx_mode = RX_FREE;
    int      rx_hold = 0;

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout at %0t with %0d reports outstanding", $time, pending_reports.size());
        $display("Mismatches found");
        $finish;
    end

    function automatic logic is_high_profile(input logic [7:0] prof);
        return prof == PROFILE_HIGH || prof == PROFILE_HIGH10 ||
               prof == PROFILE_HIGH422 || prof == PROFILE_HIGH444;
    endfunction

    function automatic int field_len(input t_step s);
        if (s == ST_HDR || s == ST_PROFILE || s == ST_FLAGS || s == ST_LEVEL ||
            s == ST_SCAL_FLAGS)
            return 8;
        if (s == ST_RESID || s == ST_BYPASS || s == ST_SCAL_PRES || s == ST_DELTA_ZERO ||
            s == ST_GAPS)
            return 1;
        return 0;
    endfunction

    function automatic void sps_clear();
        sps_step       = ST_HDR;
        sps_bits_left  = '0;
        sps_in_suffix  = 1'b0;
        sps_zeros      = '0;
        sps_acc        = '0;
        sps_profile    = '0;
        sps_poc_kind   = '0;
        sps_cycle_left = '0;
        sps_width_m1   = '0;
        sps_height_m1  = '0;
        sps_outcome    = '0;
    endfunction

    function automatic void sps_stop(input t_status st);
        sps_outcome = st + 3'd1;
        sps_step    = ST_DONE;
    endfunction

    function automatic void sps_close_element(input logic [31:0] v);
        t_step nxt;
        nxt           = sps_step + 5'd1;
        sps_bits_left = '0;
        sps_in_suffix = 1'b0;
        sps_zeros     = '0;
        sps_acc       = '0;
        case (sps_step)
            ST_HDR: begin
                if (v[4:0] != NAL_TYPE_SPS) begin
                    sps_stop(STATUS_NOT_SPS);
                    return;
                end
            end
            ST_PROFILE: sps_profile = v[7:0];
            ST_SPS_ID: begin
                if (!is_high_profile(sps_profile)) nxt = ST_FRAME_NUM;
            end
            ST_CHROMA: nxt = (v == CHROMA_444) ? ST_RESID : ST_DEPTH_L;
            ST_SCAL_PRES: nxt = (v != 0) ? ST_SCAL_FLAGS : ST_FRAME_NUM;
            ST_POC_TYPE: begin
                sps_poc_kind = (v == 0) ? 2'd0 : (v == 1) ? 2'd1 : 2'd2;
                nxt = (v == 0) ? ST_POC_LSB : (v == 1) ? ST_DELTA_ZERO : ST_NUM_REF;
            end
            ST_POC_LSB: nxt = ST_NUM_REF;
            ST_CYCLE_LEN: begin
                sps_cycle_left = v;
                nxt = (v == 0) ? ST_NUM_REF : ST_CYCLE_OFF;
            end
            ST_CYCLE_OFF: begin
                sps_cycle_left = sps_cycle_left - 32'd1;
                nxt = (sps_cycle_left == 0) ? ST_NUM_REF : ST_CYCLE_OFF;
            end
            ST_WIDTH: begin
                if (v >= 32'(MAX_MBS)) begin
                    sps_stop(STATUS_TOO_BIG);
                    return;
                end
                sps_width_m1 = v[12:0];
            end
            ST_HEIGHT: begin
                if (v >= 32'(MAX_MBS)) begin
                    sps_stop(STATUS_TOO_BIG);
                    return;
                end
                sps_height_m1 = v[12:0];
                sps_stop(STATUS_OK);
                return;
            end
            default: ;
        endcase
        sps_step = nxt;
    endfunction

    function automatic void sps_take_bit(input logic b);
        int flen;
        if (sps_outcome != 3'd0 || sps_step >= ST_DONE) return;
        flen = field_len(sps_step);
        if (flen != 0) begin
            if (sps_bits_left == 4'd0) begin
                sps_bits_left = 4'(flen);
                sps_acc       = '0;
            end
            sps_acc = {sps_acc[30:0], b};
            sps_bits_left--;
            if (sps_bits_left == 4'd0) sps_close_element(sps_acc);
        end else if (!sps_in_suffix) begin
            if (!b) begin
                if (sps_zeros >= 6'd31) sps_stop(STATUS_LONG);
                else sps_zeros++;
            end else if (sps_zeros == 6'd0) begin
                sps_close_element(32'd0);
            end else begin
                sps_acc       = 32'd1;
                sps_in_suffix = 1'b1;
            end
        end else begin
            sps_acc = {sps_acc[30:0], b};
            sps_zeros--;
            if (sps_zeros == 6'd0) sps_close_element(sps_acc - 32'd1);
        end
    endfunction

    // Feed one byte MSB first; on the last byte build the report and rearm.
    function automatic logic sps_absorb(input logic [7:0] nal_byte, input logic is_last,
                                        output t_result rep);
        logic [31:0] w_px;
        logic [31:0] h_px;
        for (int i = 7; i >= 0; i--) sps_take_bit(nal_byte[i]);
        rep = '0;
        if (!is_last) return 1'b0;
        rep.status = (sps_outcome == 3'd0) ? STATUS_EARLY : t_status'(sps_outcome - 3'd1);
        if (rep.status == STATUS_OK) begin
            w_px = (32'(sps_width_m1) + 32'd1) * 32'd16;
            h_px = (32'(sps_height_m1) + 32'd1) * 32'd16;
            rep.frame_width  = w_px[SIZE_W-1:0];
            rep.frame_height = h_px[SIZE_W-1:0];
        end
        sps_clear();
        return 1'b1;
    endfunction

    function automatic void check_report(input logic [OUT_DATA_W-1:0] beat);
        t_result want;
        t_result got;
        got = beat[2*SIZE_W+STATUS_W-1:0];
        if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, beat);
            faults++;
            return;
        end
        want = pending_reports.pop_front();
        if (got.status != want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            faults++;
        end
        if (got.frame_width != want.frame_width) begin
            $display("%0t: frame_width exp %0d got %0d", $time, want.frame_width,
                     got.frame_width);
            faults++;
        end
        if (got.frame_height != want.frame_height) begin
            $display("%0t: frame_height exp %0d got %0d", $time, want.frame_height,
                     got.frame_height);
            faults++;
        end
        if (beat[OUT_DATA_W-1:2*SIZE_W+STATUS_W] != '0) begin
            $display("%0t: pad bits exp 0 got %b", $time,
                     beat[OUT_DATA_W-1:2*SIZE_W+STATUS_W]);
            faults++;
        end
    endfunction

    // Result side: check each beat, then pick the next ready level by mode.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready) check_report(o_m_axis_tdata);
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            case (rx_mode)
                RX_FREE: begin
                    m_tready <= 1'b1;
                    rx_hold  <= 4;
                end
                RX_CHOPPY: begin
                    m_tready <= ~m_tready;
                    rx_hold  <= $urandom_range(0, 5);
                end
                default: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                    rx_hold  <= $urandom_range(2, 24);
                end
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] nal_byte, input logic is_last);
        int      gap;
        t_result rep;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (tx_gap_max > 0) gap = $urandom_range(0, tx_gap_max);
        end
        burst_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= nal_byte;
        s_tlast  <= is_last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        bytes_sent++;
        if (sps_absorb(nal_byte, is_last, rep)) begin
            pending_reports.push_back(rep);
            status_hits[rep.status]++;
            nal_count++;
        end
    endtask

    task automatic hold_until_drained();
        if (pending_reports.size() != 0) begin
            s_tvalid <= 1'b0;
            while (pending_reports.size() != 0) @(posedge i_clk);
        end
    endtask

    function automatic void put_bits(input logic [63:0] value, input int n);
        for (int i = n - 1; i >= 0; i--) nal_bits.push_back(value[i]);
    endfunction

    function automatic void put_ue(input longint unsigned v);
        logic [63:0] code;
        int          n;
        code = v + 1;
        n = 0;
        while ((code >> n) != 0) n++;
        for (int i = 0; i < n - 1; i++) nal_bits.push_back(1'b0);
        put_bits(code, n);
    endfunction

    function automatic void put_se(input longint v);
        put_ue((v > 0) ? longint'(2 * v - 1) : longint'(-2 * v));
    endfunction

    function automatic longint rand_offset(input logic big);
        if (big) return $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483647;
        // the most negative value needs a 33-bit code
        if ($urandom_range(0, 40) == 0) return -64'sd2147483648;
        return longint'($urandom_range(0, 2000)) - 1000;
    endfunction

    function automatic longint unsigned rand_size();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 16) return $urandom_range(0, 63);
        if (pick < 18) return $urandom_range(MAX_MBS - 8, MAX_MBS - 1);
        if (pick == 18) return $urandom_range(MAX_MBS, MAX_MBS + 64);
        return 64'($urandom) % 64'hFFFF_FFFF;
    endfunction

    // Pad to whole bytes, add trailing bytes, then stream the unit out.
    task automatic send_nal(input int trail);
        int         nbytes;
        logic [7:0] b;
        while (nal_bits.size() == 0 || nal_bits.size() % 8 != 0)
            nal_bits.push_back($urandom_range(0, 1));
        repeat (trail) put_bits($urandom, 8);
        nbytes = nal_bits.size() / 8;
        for (int i = 0; i < nbytes; i++) begin
            for (int j = 0; j < 8; j++) b[7-j] = nal_bits[i*8+j];
            send_byte(b, i == nbytes - 1);
        end
        nal_bits.delete();
    endtask

    task automatic emit_raw(input logic [7:0] hdr, input int extra);
        put_bits(hdr, 8);
        repeat (extra) put_bits($urandom, 8);
        send_nal(0);
    endtask

    task automatic emit_sps(input sps_plan_t p);
        longint unsigned n;
        int              cut;
        put_bits({p.hdr_top, NAL_TYPE_SPS}, 8);
        put_bits(p.profile, 8);
        put_bits($urandom, 16);
        put_ue($urandom_range(0, 31));
        if (is_high_profile(p.profile)) begin
            put_ue(p.chroma);
            if (p.chroma == CHROMA_444) put_bits(p.resid, 1);
            put_ue($urandom_range(0, 6));
            put_ue($urandom_range(0, 6));
            put_bits($urandom, 1);
            put_bits(p.scal_pres, 1);
            if (p.scal_pres) put_bits($urandom, 8);
        end
        put_ue($urandom_range(0, 12));
        put_ue(p.order_kind);
        if (p.order_kind == ORDER_KIND_LSB) begin
            put_ue($urandom_range(0, 12));
        end else if (p.order_kind == ORDER_KIND_DELTA) begin
            put_bits($urandom, 1);
            put_se(rand_offset(p.big_offsets));
            put_se(rand_offset(p.big_offsets));
            put_ue(p.cycle_len);
            // cap the offsets written; longer cycles end the unit early
            n = (p.cycle_len > OFFSET_CAP) ? OFFSET_CAP : p.cycle_len;
            for (longint unsigned i = 0; i < n; i++) put_se(rand_offset(p.big_offsets));
        end
        put_ue($urandom_range(0, 16));
        put_bits($urandom, 1);
        if (p.long_width) begin
            repeat (32 + $urandom_range(0, 8)) nal_bits.push_back(1'b0);
        end else begin
            put_ue(p.width);
        end
        put_ue(p.height);
        put_bits(1, 1);
        if (p.drop_bits != 0) begin
            cut = (p.drop_bits < 0) ? $urandom_range(1, nal_bits.size() - 1) : p.drop_bits;
            repeat (cut) if (nal_bits.size() > 1) void'(nal_bits.pop_back());
        end
        send_nal(p.trail);
    endtask

    function automatic sps_plan_t base_plan();
        sps_plan_t p;
        p.hdr_top     = 3'b011;
        p.profile     = PROFILE_BASELINE;
        p.chroma      = 1;
        p.resid       = 1'b0;
        p.scal_pres   = 1'b0;
        p.order_kind  = ORDER_KIND_LSB;
        p.cycle_len   = 2;
        p.big_offsets = 1'b0;
        p.width       = 19;
        p.height      = 14;
        p.long_width  = 1'b0;
        p.trail       = 0;
        p.drop_bits   = 0;
        return p;
    endfunction

    function automatic sps_plan_t random_plan();
        sps_plan_t p;
        int        pick;
        p = base_plan();
        p.hdr_top = 3'($urandom);
        case ($urandom_range(0, 7))
            0: p.profile = PROFILE_BASELINE;
            1: p.profile = PROFILE_MAIN;
            2: p.profile = PROFILE_EXTENDED;
            3: p.profile = PROFILE_HIGH;
            4: p.profile = PROFILE_HIGH10;
            5: p.profile = PROFILE_HIGH422;
            6: p.profile = PROFILE_HIGH444;
            default: p.profile = 8'($urandom);
        endcase
        p.chroma    = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 300) : $urandom_range(0, 3);
        p.resid     = $urandom_range(0, 1);
        p.scal_pres = $urandom_range(0, 1);
        pick = $urandom_range(0, 9);
        p.order_kind = (pick < 4) ? ORDER_KIND_LSB : (pick < 8) ? ORDER_KIND_DELTA :
                       (pick == 8) ? ORDER_KIND_NONE : 64'($urandom_range(3, 70000));
        pick = $urandom_range(0, 29);
        p.cycle_len = (pick == 0) ? 64'($urandom_range(OFFSET_CAP + 1, 100000)) :
                      (pick < 4) ? 64'($urandom_range(7, 40)) : 64'($urandom_range(0, 6));
        p.big_offsets = ($urandom_range(0, 15) == 0);
        p.width  = rand_size();
        p.height = rand_size();
        p.trail  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        return p;
    endfunction

    task automatic test_header_cases();
        emit_raw({3'b011, NAL_TYPE_IDR}, 3);
        emit_raw({3'b000, NAL_TYPE_UNSPEC}, 0);
        emit_raw({3'b111, NAL_TYPE_TOP}, 1);
        // forbidden bit set on an SPS header, nothing after it
        emit_raw({3'b100, NAL_TYPE_SPS}, 0);
    endtask

    task automatic test_profile_branches();
        sps_plan_t p;
        emit_sps(base_plan());
        p = base_plan();
        p.profile    = PROFILE_HIGH;
        p.order_kind = ORDER_KIND_DELTA;
        p.cycle_len  = 3;
        emit_sps(p);
        p = base_plan();
        p.profile    = PROFILE_HIGH10;
        p.chroma     = CHROMA_444;
        p.resid      = 1'b1;
        p.scal_pres  = 1'b1;
        p.order_kind = ORDER_KIND_NONE;
        emit_sps(p);
        p = base_plan();
        p.profile    = PROFILE_HIGH422;
        p.chroma     = 0;
        p.scal_pres  = 1'b1;
        p.order_kind = ORDER_KIND_RESERVED;
        emit_sps(p);
        p = base_plan();
        p.profile    = PROFILE_HIGH444;
        p.chroma     = CHROMA_444;
        p.order_kind = ORDER_KIND_DELTA;
        p.cycle_len  = 0;
        emit_sps(p);
        p = base_plan();
        p.profile    = PROFILE_MAIN;
        p.order_kind = ORDER_KIND_NONE;
        emit_sps(p);
        p = base_plan();
        p.profile = PROFILE_EXTENDED;
        p.chroma  = CHROMA_444;
        emit_sps(p);
    endtask

    task automatic test_size_limits();
        sps_plan_t p;
        p = base_plan();
        p.width  = 0;
        p.height = 0;
        emit_sps(p);
        p.width  = MAX_MBS - 1;
        p.height = MAX_MBS - 1;
        emit_sps(p);
        p.width = MAX_MBS;
        emit_sps(p);
        p.width  = 7;
        p.height = MAX_MBS;
        emit_sps(p);
        p.width = 64'hFFFF_FFFE;
        emit_sps(p);
    endtask

    task automatic test_error_paths();
        sps_plan_t p;
        p = base_plan();
        p.long_width = 1'b1;
        emit_sps(p);
        p = base_plan();
        p.order_kind  = ORDER_KIND_DELTA;
        p.big_offsets = 1'b1;
        emit_sps(p);
        // cut inside a long height code so the unit ends before it completes
        p = base_plan();
        p.height    = 1000;
        p.drop_bits = 12;
        emit_sps(p);
        p = base_plan();
        p.trail = 3;
        emit_sps(p);
        p = base_plan();
        p.order_kind = ORDER_KIND_DELTA;
        p.cycle_len  = 64'hFFFF_FFFE;
        emit_sps(p);
    endtask

    task automatic test_random_streams();
        sps_plan_t p;
        int        pick;
        int        stop_at;
        int        units;
        stop_at = bytes_sent + 900;
        units = 0;
        while (bytes_sent < stop_at) begin
            if (units % 16 == 0) begin
                pick = $urandom_range(0, 2);
                tx_gap_max = (pick == 0) ? 0 : (pick == 1) ? 2 : 8;
                rx_mode = $urandom_range(RX_FREE, RX_CHOKED);
            end
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                emit_sps(random_plan());
            end else if (pick < 72) begin
                p = random_plan();
                p.drop_bits = -1;
                emit_sps(p);
            end else if (pick < 76) begin
                p = random_plan();
                p.long_width = 1'b1;
                emit_sps(p);
            end else if (pick < 84) begin
                pick = $urandom_range(0, 255);
                if (pick[4:0] == NAL_TYPE_SPS) pick[0] = 1'b0;
                emit_raw(8'(pick), $urandom_range(0, 6));
            end else begin
                emit_raw({3'($urandom), NAL_TYPE_SPS}, $urandom_range(1, 14));
            end
            units++;
        end
    endtask

    task automatic test_output_stall();
        rx_mode    = RX_CHOKED;
        tx_gap_max = 0;
        repeat (5) emit_sps(random_plan());
        hold_until_drained();
        rx_mode = RX_FREE;
        repeat (5) emit_sps(random_plan());
    endtask

    initial begin
        sps_clear();
        repeat (5) @(posedge i_clk);
        i_rst_n    <= 1'b1;
        tx_gap_max = 2;
        rx_mode    = RX_CHOPPY;
        test_header_cases();
        test_profile_branches();
        test_size_limits();
        test_error_paths();
        test_random_streams();
        test_output_stall();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Run covered %0d bytes in %0d NAL units under mixed gaps and stalls",
                 bytes_sent, nal_count);
        $display("Reports by status: ok %0d, not SPS %0d, early end %0d, long code %0d, %s %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 "too big", status_hits[4]);
        if (faults == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sfp_pkg.sv
rtl/sfp_bit_step.sv
rtl/sfp_parse_engine.sv
rtl/h264_sps_frame_size_parser_core.sv
rtl/sfp_checker.sv
dv/tb_h264_sps_frame_size_parser_core.sv
